// File: rtl/core/itf_pkg.sv
// Shared types and constants for the IMU tilt fusion block.
// Depends on nothing; used by the channel interfaces, the CORDIC unit and the top level.
package itf_pkg;

   localparam int RAW_W    = 16;
   localparam int CORDIC_W = 28;   // x/y datapath: 17-bit operand scaled by 256 plus gain
   localparam int ZANG_W   = 26;   // angle in 2^-16 degree, covers +-180 plus residue
   localparam int ATAN_W   = 22;
   localparam int TAB_LEN  = 24;
   localparam int IDX_W    = 5;

   // 1962*a > 1760*32768  <=>  a > 29394 ; 1962*a < 245*32768 <=> a <= 4091
   localparam logic signed [RAW_W-1:0] IMPACT_MAX = 16'sd29394;
   localparam logic signed [RAW_W-1:0] FFALL_MAX  = 16'sd4091;

   localparam logic signed [ZANG_W-1:0] HALF_TURN = 26'sd11796480;  // 180 deg

   typedef enum logic [2:0] {
      REG_GYRO_OFFSET_X = 3'd0,
      REG_GYRO_OFFSET_Y = 3'd1,
      REG_GYRO_OFFSET_Z = 3'd2,
      REG_ROLL_OFFSET   = 3'd3,
      REG_PITCH_OFFSET  = 3'd4,
      REG_BLEND_WEIGHT  = 3'd5,
      REG_ANGLE_LIMIT   = 3'd6,
      REG_RATE_LIMIT    = 3'd7
   } reg_index_type;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_CORDIC = 6'b000010,
      ST_MUL    = 6'b000100,
      ST_DIV    = 6'b001000,
      ST_SAT    = 6'b010000,
      ST_DONE   = 6'b100000
   } state_type;

   // atan(2^-i) in 2^-16 degree
   function automatic logic [ATAN_W-1:0] atan_lookup(input logic [IDX_W-1:0] idx);
      logic [ATAN_W-1:0] v;
      case (idx)
         5'd0:  v = 22'd2949120;
         5'd1:  v = 22'd1740967;
         5'd2:  v = 22'd919879;
         5'd3:  v = 22'd466945;
         5'd4:  v = 22'd234379;
         5'd5:  v = 22'd117304;
         5'd6:  v = 22'd58666;
         5'd7:  v = 22'd29335;
         5'd8:  v = 22'd14668;
         5'd9:  v = 22'd7334;
         5'd10: v = 22'd3667;
         5'd11: v = 22'd1833;
         5'd12: v = 22'd917;
         5'd13: v = 22'd458;
         5'd14: v = 22'd229;
         5'd15: v = 22'd115;
         5'd16: v = 22'd57;
         5'd17: v = 22'd29;
         5'd18: v = 22'd14;
         5'd19: v = 22'd7;
         5'd20: v = 22'd4;
         5'd21: v = 22'd2;
         5'd22: v = 22'd1;
         default: v = 22'd0;
      endcase
      return v;
   endfunction

endpackage

// File: rtl/core/itf_channels.sv
// Valid/ready channel interfaces: sample request, fused result, register write.
// Depends on itf_pkg for field widths.
interface itf_req_if;
   import itf_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [RAW_W-1:0] accel_x;
   logic signed [RAW_W-1:0] accel_y;
   logic signed [RAW_W-1:0] accel_z;
   logic signed [RAW_W-1:0] rate_x;
   logic signed [RAW_W-1:0] rate_y;
   logic signed [RAW_W-1:0] rate_z;
   logic [RAW_W-1:0]        elapsed_us;
   modport source (output valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
                   elapsed_us, input ready);
   modport sink (input valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
                 elapsed_us, output ready);
endinterface

interface itf_rsp_if;
   import itf_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [RAW_W-1:0] roll_est;
   logic signed [RAW_W-1:0] pitch_est;
   logic signed [RAW_W-1:0] roll_tilt;
   logic signed [RAW_W-1:0] pitch_tilt;
   logic [4:0]              fault_bits;
   logic                    stopped;
   modport source (output valid, roll_est, pitch_est, roll_tilt, pitch_tilt, fault_bits,
                   stopped, input ready);
   modport sink (input valid, roll_est, pitch_est, roll_tilt, pitch_tilt, fault_bits,
                 stopped, output ready);
endinterface

interface itf_csr_if;
   import itf_pkg::*;
   logic             valid;
   logic             ready;
   logic [2:0]       index;
   logic [RAW_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/core/imu_tilt_fusion_with_safety_trip_unit.sv
// Top level of the IMU tilt fusion block: register file, sequencer, shared multiplier,
// reciprocal divide by 125 and safety checks. Depends on itf_pkg, itf_channels, itf_cordic.
//
// Usage: one sample transaction on req_ch (six raw 16-bit axes plus elapsed microseconds)
// yields one result transaction on rsp_ch: fused roll/pitch, accelerometer tilts,
// five fault bits and the sticky stopped flag. csr_ch writes the eight registers at any
// time; it is always ready. Write registers only while no sample is in flight.
// Sequence: two CORDIC passes (roll, then pitch), then per axis the multiplier steps,
// a reciprocal multiply for the divide by 125 and a saturate step, then the result is
// loaded into the output register. req_ch.ready returns high in the same cycle that
// rsp_ch.valid rises; the CORDIC iterations take most of the time spent on one
// sample.
// req_ch.ready is high only while the sequencer is idle, so one sample is worked at a time.
// A finished result sits in the output register until taken; if rsp_ch stalls, the
// next sample is accepted and worked, and its result waits for the register to free.
// Reset (synchronous) clears both fused angles and the stop flag and loads register
// defaults: blend weight 51/256, angle limit 45 degrees, rate limit 19661 counts.
module imu_tilt_fusion_with_safety_trip_unit #(
   parameter int CORDIC_STEPS    = 16,
   parameter int ANGLE_FRAC_BITS = 7
) (
   input  logic      clock,
   input  logic      reset,
   itf_req_if.sink   req_ch,
   itf_rsp_if.source rsp_ch,
   itf_csr_if.sink   csr_ch
);
   import itf_pkg::*;

   localparam int MA_W   = 28;
   localparam int MB_W   = 24;
   localparam int NUM_W  = MA_W + MB_W;
   localparam int SHIFT  = 27 - ANGLE_FRAC_BITS;
   localparam int DIV_W  = NUM_W - SHIFT;
   localparam int TSH    = 16 - ANGLE_FRAC_BITS;
   localparam int RATE_W = RAW_W + 2;
   // floor(m/125) == (m*RECIP) >> RECIP_SH for every m below 2^MAG_W;
   // larger m saturate anyway, so m is clipped to MAG_W bits
   localparam int MAG_W    = 22;
   localparam int Q_W      = 16;
   localparam int RECIP_SH = 29;
   localparam logic signed [MB_W-1:0]   RECIP = 24'sd4294968;
   localparam logic signed [MB_W-1:0]   DEN  = MB_W'(125 * (2 ** (19 - ANGLE_FRAC_BITS)));
   localparam logic signed [NUM_W-1:0]  HALF = NUM_W'(125 * (2 ** (26 - ANGLE_FRAC_BITS)));
   localparam logic signed [ZANG_W-1:0] TRND = ZANG_W'(2 ** (TSH - 1));
   localparam logic signed [RAW_W-1:0]  ANG_MAX = 16'sd32767;

   // configuration registers
   logic signed [RAW_W-1:0] gofs_x_ff, gofs_y_ff, gofs_z_ff, roll_ofs_ff, pitch_ofs_ff;
   logic [8:0]              blend_ff;
   logic [14:0]             angle_lim_ff, rate_lim_ff;

   state_type state_ff;
   logic      axis_ff;
   logic [2:0] mstep_ff;

   logic signed [RAW_W-1:0]  ax_ff, ay_ff, az_ff;
   logic [RAW_W-1:0]         dt_ff;
   logic signed [RATE_W-1:0] rx_ff, ry_ff, rz_ff;
   logic signed [RAW_W-1:0]  roll_acc_ff, pitch_acc_ff, roll_tilt_ff, pitch_tilt_ff;
   logic                     halted_ff;
   logic signed [NUM_W-1:0]  t_ff, u_ff;
   logic [MAG_W-1:0]         mag_ff;
   logic [Q_W-1:0]           quo_ff;
   logic                     neg_ff;

   logic rsp_valid_ff;
   logic signed [RAW_W-1:0] out_roll_ff, out_pitch_ff, out_rtilt_ff, out_ptilt_ff;
   logic [4:0] out_fault_ff;
   logic       out_stop_ff;

   logic accept, cordic_start, cordic_done, load_out;
   logic signed [RAW_W:0]    cx, cy;
   logic signed [ZANG_W-1:0] cang, tshift, traw;
   logic signed [RAW_W-1:0]  tsat;
   logic [8:0]               w, wc;
   logic signed [MA_W-1:0]   ma;
   logic signed [MB_W-1:0]   mb;
   logic signed [NUM_W-1:0]  prod, rsum, n2full;
   logic [DIV_W-1:0]         n2, mag;
   logic [MAG_W-1:0]         mag_clip;
   logic signed [Q_W:0]      qs;
   logic signed [RAW_W-1:0]  qsat;
   logic signed [RAW_W-1:0]  cur_tilt, cur_angle;
   logic signed [RATE_W-1:0] cur_rate;
   logic [4:0]               faults;
   logic                     out_free;
   logic signed [RAW_W:0]    lim_p, lim_n;
   logic signed [RATE_W-1:0] rlim;

   assign accept       = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         gofs_x_ff    <= '0;
         gofs_y_ff    <= '0;
         gofs_z_ff    <= '0;
         roll_ofs_ff  <= '0;
         pitch_ofs_ff <= '0;
         blend_ff     <= 9'd51;
         angle_lim_ff <= 15'd5760;
         rate_lim_ff  <= 15'd19661;
      end else if (csr_ch.valid) begin
         case (reg_index_type'(csr_ch.index))
            REG_GYRO_OFFSET_X: gofs_x_ff    <= csr_ch.data;
            REG_GYRO_OFFSET_Y: gofs_y_ff    <= csr_ch.data;
            REG_GYRO_OFFSET_Z: gofs_z_ff    <= csr_ch.data;
            REG_ROLL_OFFSET:   roll_ofs_ff  <= csr_ch.data;
            REG_PITCH_OFFSET:  pitch_ofs_ff <= csr_ch.data;
            REG_BLEND_WEIGHT:  blend_ff     <= csr_ch.data[8:0];
            REG_ANGLE_LIMIT:   angle_lim_ff <= csr_ch.data[14:0];
            REG_RATE_LIMIT:    rate_lim_ff  <= csr_ch.data[14:0];
            default: ;
         endcase
      end
   end

   // CORDIC operands: roll uses (ay, -az), pitch uses (ax, -az)
   always_comb begin
      if (accept) begin
         cx = -$signed({req_ch.accel_z[RAW_W-1], req_ch.accel_z});
         cy = $signed({req_ch.accel_y[RAW_W-1], req_ch.accel_y});
      end else begin
         cx = -$signed({az_ff[RAW_W-1], az_ff});
         cy = $signed({ax_ff[RAW_W-1], ax_ff});
      end
      cordic_start = accept || (state_ff == ST_CORDIC && cordic_done && !axis_ff);
   end

   itf_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cordic_start),
      .x_in  (cx),
      .y_in  (cy),
      .done  (cordic_done),
      .angle (cang)
   );

   // tilt: round to the angle unit, remove the offset, saturate
   always_comb begin
      tshift = (cang + TRND) >>> TSH;
      traw   = tshift - ZANG_W'(axis_ff ? pitch_ofs_ff : roll_ofs_ff);
      if (traw > ZANG_W'(ANG_MAX))
         tsat = ANG_MAX;
      else if (traw < -ZANG_W'(ANG_MAX))
         tsat = -ANG_MAX;
      else
         tsat = traw[RAW_W-1:0];
   end

   // shared multiplier
   always_comb begin
      w         = blend_ff[8] ? 9'd256 : blend_ff;
      wc        = 9'd256 - w;
      cur_tilt  = axis_ff ? pitch_tilt_ff : roll_tilt_ff;
      cur_angle = axis_ff ? pitch_acc_ff : roll_acc_ff;
      cur_rate  = axis_ff ? ry_ff : rx_ff;
      case (mstep_ff)
         3'd0: begin
            ma = MA_W'(cur_tilt);
            mb = $signed({{(MB_W-9){1'b0}}, w});
         end
         3'd1: begin
            ma = MA_W'(cur_angle);
            mb = $signed({{(MB_W-9){1'b0}}, wc});
         end
         3'd2: begin
            ma = t_ff[MA_W-1:0];
            mb = DEN;
         end
         3'd3: begin
            ma = MA_W'(cur_rate);
            mb = $signed({{(MB_W-9){1'b0}}, wc});
         end
         3'd4: begin
            ma = u_ff[MA_W-1:0];
            mb = $signed({{(MB_W-RAW_W){1'b0}}, dt_ff});
         end
         3'd6: begin
            ma = $signed({{(MA_W-MAG_W){1'b0}}, mag_ff});
            mb = RECIP;
         end
         default: begin
            ma = '0;
            mb = '0;
         end
      endcase
      prod = ma * mb;
   end

   // rounding and floor division by 125 * 2^SHIFT
   always_comb begin
      rsum     = t_ff + u_ff + HALF;
      n2full   = rsum >>> SHIFT;
      n2       = n2full[DIV_W-1:0];
      mag      = rsum[NUM_W-1] ? (DIV_W'(124) - n2) : n2;
      mag_clip = (|mag[DIV_W-1:MAG_W]) ? {MAG_W{1'b1}} : mag[MAG_W-1:0];
      qs       = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
      if (qs > (Q_W+1)'(ANG_MAX))
         qsat = ANG_MAX;
      else if (qs < -(Q_W+1)'(ANG_MAX))
         qsat = -ANG_MAX;
      else
         qsat = qs[RAW_W-1:0];
   end

   // safety checks on the accelerations, the new angles and the rates
   always_comb begin
      lim_p  = $signed({2'b0, angle_lim_ff});
      lim_n  = -lim_p;
      rlim   = $signed({{(RATE_W-15){1'b0}}, rate_lim_ff});
      faults = '0;
      faults[0] = (ax_ff > IMPACT_MAX) || (ay_ff > IMPACT_MAX) || (az_ff > IMPACT_MAX);
      faults[1] = (ax_ff <= FFALL_MAX) && (ay_ff <= FFALL_MAX) && (az_ff > FFALL_MAX);
      faults[2] = (17'(roll_acc_ff) > lim_p) || (17'(roll_acc_ff) < lim_n);
      faults[3] = (17'(pitch_acc_ff) > lim_p) || (17'(pitch_acc_ff) < lim_n);
      faults[4] = (rx_ff > rlim) || (ry_ff > rlim) || (rz_ff > rlim);
      out_free  = !rsp_valid_ff || rsp_ch.ready;
      load_out  = (state_ff == ST_DONE) && out_free;
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         axis_ff      <= 1'b0;
         mstep_ff     <= '0;
         roll_acc_ff  <= '0;
         pitch_acc_ff <= '0;
         halted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_ch.ready && !load_out)
            rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  axis_ff  <= 1'b0;
                  state_ff <= ST_CORDIC;
               end
            end
            ST_CORDIC: begin
               if (cordic_done) begin
                  if (axis_ff) begin
                     axis_ff  <= 1'b0;
                     mstep_ff <= '0;
                     state_ff <= ST_MUL;
                  end else begin
                     axis_ff <= 1'b1;
                  end
               end
            end
            ST_MUL: begin
               if (mstep_ff == 3'd5)
                  state_ff <= ST_DIV;
               mstep_ff <= mstep_ff + 3'd1;
            end
            ST_DIV: begin
               state_ff <= ST_SAT;
            end
            ST_SAT: begin
               if (axis_ff) begin
                  pitch_acc_ff <= qsat;
                  state_ff     <= ST_DONE;
               end else begin
                  roll_acc_ff <= qsat;
                  axis_ff     <= 1'b1;
                  mstep_ff    <= '0;
                  state_ff    <= ST_MUL;
               end
            end
            ST_DONE: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  halted_ff    <= halted_ff | (faults != '0);
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (accept) begin
         ax_ff <= req_ch.accel_x;
         ay_ff <= req_ch.accel_y;
         az_ff <= req_ch.accel_z;
         dt_ff <= req_ch.elapsed_us;
         rx_ff <= -RATE_W'(req_ch.rate_x) - RATE_W'(gofs_x_ff);
         ry_ff <= RATE_W'(req_ch.rate_y) - RATE_W'(gofs_y_ff);
         rz_ff <= RATE_W'(req_ch.rate_z) - RATE_W'(gofs_z_ff);
      end
      if (state_ff == ST_CORDIC && cordic_done) begin
         if (axis_ff)
            pitch_tilt_ff <= tsat;
         else
            roll_tilt_ff <= tsat;
      end
      if (state_ff == ST_MUL) begin
         case (mstep_ff)
            3'd0: t_ff <= prod;
            3'd1: t_ff <= t_ff + prod;
            3'd2: t_ff <= prod;
            3'd3: u_ff <= prod;
            3'd4: u_ff <= prod;
            3'd5: begin
               neg_ff <= rsum[NUM_W-1];
               mag_ff <= mag_clip;
            end
            default: ;
         endcase
      end
      if (state_ff == ST_DIV)
         quo_ff <= prod[RECIP_SH +: Q_W];
      if (load_out) begin
         out_roll_ff  <= roll_acc_ff;
         out_pitch_ff <= pitch_acc_ff;
         out_rtilt_ff <= roll_tilt_ff;
         out_ptilt_ff <= pitch_tilt_ff;
         out_fault_ff <= faults;
         out_stop_ff  <= halted_ff | (faults != '0);
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.roll_est   = out_roll_ff;
   assign rsp_ch.pitch_est  = out_pitch_ff;
   assign rsp_ch.roll_tilt  = out_rtilt_ff;
   assign rsp_ch.pitch_tilt = out_ptilt_ff;
   assign rsp_ch.fault_bits = out_fault_ff;
   assign rsp_ch.stopped    = out_stop_ff;

endmodule

// File: rtl/core/itf_cordic.sv
// Iterative vectoring CORDIC: atan2(y, x) in 2^-16 degree, one micro-rotation per cycle.
// Depends on itf_pkg (arctangent table, widths).
module itf_cordic #(
   parameter int STEPS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic signed [itf_pkg::RAW_W:0] x_in,
   input  logic signed [itf_pkg::RAW_W:0] y_in,
   output logic                           done,
   output logic signed [itf_pkg::ZANG_W-1:0] angle
);
   import itf_pkg::*;

   localparam int IW = (STEPS > 1) ? $clog2(STEPS) : 1;

   logic signed [CORDIC_W-1:0] x_ff, x_in_v, y_ff, y_in_v;
   logic signed [ZANG_W-1:0]   z_ff, base_ff;
   logic [IW-1:0]              i_ff;
   logic                       busy_ff, done_ff, zero_ff;
   logic signed [RAW_W:0]      xs, ys;
   logic signed [CORDIC_W-1:0] dx, dy;
   logic signed [ZANG_W-1:0]   step_ang;

   always_comb begin
      xs = x_in[RAW_W] ? -x_in : x_in;
      ys = x_in[RAW_W] ? -y_in : y_in;
      x_in_v = $signed({{3{xs[RAW_W]}}, xs, 8'b0});
      y_in_v = $signed({{3{ys[RAW_W]}}, ys, 8'b0});
      dx = y_ff >>> i_ff;
      dy = x_ff >>> i_ff;
      step_ang = $signed({{(ZANG_W-ATAN_W){1'b0}}, atan_lookup(IDX_W'(i_ff))});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && i_ff == IW'(STEPS - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff    <= x_in_v;
         y_ff    <= y_in_v;
         z_ff    <= '0;
         i_ff    <= '0;
         zero_ff <= (x_in == '0) && (y_in == '0);
         if (x_in[RAW_W])
            base_ff <= y_in[RAW_W] ? -HALF_TURN : HALF_TURN;
         else
            base_ff <= '0;
      end else if (busy_ff) begin
         if (y_ff > 0) begin
            x_ff <= x_ff + dx;
            y_ff <= y_ff - dy;
            z_ff <= z_ff + step_ang;
         end else begin
            x_ff <= x_ff - dx;
            y_ff <= y_ff + dy;
            z_ff <= z_ff - step_ang;
         end
         i_ff <= i_ff + 1'b1;
      end
   end

   assign done  = done_ff;
   assign angle = zero_ff ? '0 : base_ff + z_ff;

endmodule

// File: dv/tb_imu_tilt_fusion_with_safety_trip_unit.sv
// Self-checking bench for the IMU tilt fusion block: directed and random samples,
// register sweeps, random stalls on both channels and a long result hold-off.
// Depends on itf_pkg, itf_channels and the top level imu_tilt_fusion_with_safety_trip_unit.
module tb_imu_tilt_fusion_with_safety_trip_unit;
   import itf_pkg::*;

   typedef struct {
      logic signed [15:0] ax, ay, az, gx, gy, gz;
      logic [15:0]        dt;
   } imu_sample_type;

   typedef struct {
      logic signed [15:0] roll_est, pitch_est, roll_tilt, pitch_tilt;
      logic [4:0]         fault_bits;
      logic               stopped;
   } fusion_result_type;

   localparam int  ANG_FRAC  = 7;
   localparam int  CORDIC_IT = 16;
   localparam longint ANG_SAT = 32767;

   logic clock;
   logic reset;

   itf_req_if req_ch();
   itf_rsp_if rsp_ch();
   itf_csr_if csr_ch();

   imu_tilt_fusion_with_safety_trip_unit dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch.sink),
      .rsp_ch(rsp_ch.source),
      .csr_ch(csr_ch.sink)
   );

   // predictor state
   longint            reg_shadow[8];
   longint            roll_fused, pitch_fused;
   bit                trip_latched;
   fusion_result_type fused_expected[$];

   int  mismatches;
   bit  no_gaps;
   int  rsp_hold;

   const longint atan_deg16[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
      58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};

   always #2 clock = ~clock;

   function automatic longint clamp_angle(longint v);
      if (v > ANG_SAT) return ANG_SAT;
      if (v < -ANG_SAT) return -ANG_SAT;
      return v;
   endfunction

   // atan2 in 2^-16 degree, vectoring mode with 180 degree pre-rotation
   function automatic longint atan2_deg16(longint y, longint x);
      longint base, z, dx, dy;
      base = 0;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         base = (y >= 0) ? 180 * 65536 : -180 * 65536;
         x = -x;
         y = -y;
      end
      x = x * 256;
      y = y * 256;
      for (int i = 0; i < CORDIC_IT && i < 24; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y > 0) begin
            x = x + dx; y = y - dy; z = z + atan_deg16[i];
         end else begin
            x = x - dx; y = y + dy; z = z - atan_deg16[i];
         end
      end
      return base + z;
   endfunction

   function automatic longint accel_tilt(longint y, longint x, longint offset);
      int s;
      s = 16 - ANG_FRAC;
      return clamp_angle(((atan2_deg16(y, x) + (longint'(1) << (s - 1))) >>> s) - offset);
   endfunction

   function automatic longint fuse_angle(longint tilt, longint angle, longint rate,
                                         longint dt, longint w);
      longint den, num, d, q, n;
      den = longint'(125) << (19 - ANG_FRAC);
      num = w * tilt * den + (256 - w) * (angle * den + rate * dt);
      d = 256 * den;
      n = num + d / 2;
      q = n / d;
      if ((n % d) != 0 && n < 0) q = q - 1;
      return clamp_angle(q);
   endfunction

   function automatic fusion_result_type predict_fusion(imu_sample_type s);
      fusion_result_type r;
      longint w, rx, ry, rz, rt, pt, lim, rlim;
      logic [4:0] f;
      w  = (reg_shadow[REG_BLEND_WEIGHT] > 256) ? 256 : reg_shadow[REG_BLEND_WEIGHT];
      rx = -longint'(s.gx) - reg_shadow[REG_GYRO_OFFSET_X];
      ry = longint'(s.gy) - reg_shadow[REG_GYRO_OFFSET_Y];
      rz = longint'(s.gz) - reg_shadow[REG_GYRO_OFFSET_Z];
      rt = accel_tilt(s.ay, -longint'(s.az), reg_shadow[REG_ROLL_OFFSET]);
      pt = accel_tilt(s.ax, -longint'(s.az), reg_shadow[REG_PITCH_OFFSET]);
      roll_fused  = fuse_angle(rt, roll_fused, rx, s.dt, w);
      pitch_fused = fuse_angle(pt, pitch_fused, ry, s.dt, w);
      lim  = reg_shadow[REG_ANGLE_LIMIT];
      rlim = reg_shadow[REG_RATE_LIMIT];
      f = '0;
      if (1962 * longint'(s.ax) > 1760 * 32768 || 1962 * longint'(s.ay) > 1760 * 32768 ||
          1962 * longint'(s.az) > 1760 * 32768) f[0] = 1'b1;
      if (1962 * longint'(s.ax) < 245 * 32768 && 1962 * longint'(s.ay) < 245 * 32768 &&
          1962 * longint'(s.az) > 245 * 32768) f[1] = 1'b1;
      if (roll_fused > lim || roll_fused < -lim) f[2] = 1'b1;
      if (pitch_fused > lim || pitch_fused < -lim) f[3] = 1'b1;
      if (rx > rlim || ry > rlim || rz > rlim) f[4] = 1'b1;
      if (f != 0) trip_latched = 1'b1;
      r.roll_est   = roll_fused[15:0];
      r.pitch_est  = pitch_fused[15:0];
      r.roll_tilt  = rt[15:0];
      r.pitch_tilt = pt[15:0];
      r.fault_bits = f;
      r.stopped    = trip_latched;
      return r;
   endfunction

   function automatic void reset_predictor();
      foreach (reg_shadow[i]) reg_shadow[i] = 0;
      reg_shadow[REG_BLEND_WEIGHT] = 51;
      reg_shadow[REG_ANGLE_LIMIT]  = 5760;
      reg_shadow[REG_RATE_LIMIT]   = 19661;
      roll_fused   = 0;
      pitch_fused  = 0;
      trip_latched = 0;
   endfunction

   function automatic int draw_gap();
      return no_gaps ? 0 : $urandom_range(0, 12);
   endfunction

   task automatic send_sample(imu_sample_type s);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.accel_x    <= s.ax;
      req_ch.accel_y    <= s.ay;
      req_ch.accel_z    <= s.az;
      req_ch.rate_x     <= s.gx;
      req_ch.rate_y     <= s.gy;
      req_ch.rate_z     <= s.gz;
      req_ch.elapsed_us <= s.dt;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      fused_expected.push_back(predict_fusion(s));
   endtask

   task automatic go_idle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (fused_expected.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(reg_index_type idx, logic [15:0] data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= data;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      if (idx <= REG_PITCH_OFFSET) reg_shadow[idx] = longint'(signed'(data));
      else if (idx == REG_BLEND_WEIGHT) reg_shadow[idx] = data[8:0];
      else reg_shadow[idx] = data[14:0];
      @(posedge clock);
   endtask

   function automatic imu_sample_type make_sample(int mode);
      imu_sample_type s;
      if (mode == 0) begin
         // near level, gravity on -z, modest rates
         s.ax = 16'($urandom_range(0, 16000) - 8000);
         s.ay = 16'($urandom_range(0, 16000) - 8000);
         s.az = 16'(-16384 + $urandom_range(0, 8000) - 4000);
         s.gx = 16'($urandom_range(0, 8000) - 4000);
         s.gy = 16'($urandom_range(0, 8000) - 4000);
         s.gz = 16'($urandom_range(0, 8000) - 4000);
         s.dt = 16'($urandom_range(200, 20000));
      end else begin
         s.ax = 16'($urandom); s.ay = 16'($urandom); s.az = 16'($urandom);
         s.gx = 16'($urandom); s.gy = 16'($urandom); s.gz = 16'($urandom);
         s.dt = 16'($urandom);
      end
      return s;
   endfunction

   function automatic imu_sample_type pack_sample(int ax, int ay, int az, int gx, int gy,
                                                  int gz, int dt);
      imu_sample_type s;
      s.ax = 16'(ax); s.ay = 16'(ay); s.az = 16'(az);
      s.gx = 16'(gx); s.gy = 16'(gy); s.gz = 16'(gz); s.dt = 16'(dt);
      return s;
   endfunction

   task automatic compare_field(string name, longint want, longint got);
      if (want != got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch %s: expected %0d, actual %0d", name, want, got);
      end
   endtask

   // result checker
   always @(posedge clock) begin
      fusion_result_type e;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (fused_expected.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: result with no sample outstanding");
         end else begin
            e = fused_expected.pop_front();
            compare_field("roll_est", e.roll_est, rsp_ch.roll_est);
            compare_field("pitch_est", e.pitch_est, rsp_ch.pitch_est);
            compare_field("roll_tilt", e.roll_tilt, rsp_ch.roll_tilt);
            compare_field("pitch_tilt", e.pitch_tilt, rsp_ch.pitch_tilt);
            compare_field("fault_bits", e.fault_bits, rsp_ch.fault_bits);
            compare_field("stopped", e.stopped, rsp_ch.stopped);
         end
      end
   end

   // result-side stalls; a pending hold-off takes priority
   initial begin
      int n;
      rsp_ch.ready <= 1'b0;
      @(negedge reset);
      forever begin
         if (rsp_hold > 0) begin
            n = rsp_hold;
            rsp_hold = 0;
         end else n = draw_gap();
         if (n > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
      end
   end

   task automatic test_directed_extremes();
      send_sample(pack_sample(0, 0, 0, 0, 0, 0, 0));                 // zero vector
      send_sample(pack_sample(0, 0, -16384, 0, 0, 0, 1000));         // level
      send_sample(pack_sample(0, 0, 16384, 0, 0, 0, 1000));          // upside down
      send_sample(pack_sample(0, -100, 16384, 0, 0, 0, 1000));       // negative half turn
      send_sample(pack_sample(-32768, -32768, -32768, -32768, -32768, -32768, 65535));
      send_sample(pack_sample(32767, 32767, 32767, 32767, 32767, 32767, 65535));
      send_sample(pack_sample(29394, 0, -16384, 0, 0, 0, 100));      // impact edge, quiet
      send_sample(pack_sample(29395, 0, -16384, 0, 0, 0, 100));      // impact
      send_sample(pack_sample(4091, 4091, 4092, 0, 0, 0, 100));      // free fall
      send_sample(pack_sample(4092, 0, 5000, 0, 0, 0, 100));         // free fall miss
      send_sample(pack_sample(16384, 0, 0, 0, 0, 0, 100));           // x axis vertical
      send_sample(pack_sample(0, -16384, 0, -19662, 19662, 19662, 20000)); // spin
      send_sample(pack_sample(0, 0, -16384, 19662, -19662, -32768, 0));
      send_sample(pack_sample(0, 0, -16384, 0, 0, 0, 5000));         // after stop
   endtask

   task automatic test_register_extremes();
      logic [15:0] w_vals[6] = '{16'd0, 16'd256, 16'd300, 16'hFFFF, 16'd1, 16'd51};
      foreach (w_vals[k]) begin
         go_idle();
         write_reg(REG_BLEND_WEIGHT, w_vals[k]);
         write_reg(REG_ANGLE_LIMIT, (k % 2) ? 16'hFFFF : 16'd0);
         write_reg(REG_RATE_LIMIT, (k % 2) ? 16'h7FFF : 16'd0);
         write_reg(REG_ROLL_OFFSET, (k % 2) ? 16'sd23040 : -16'sd23040);
         write_reg(REG_PITCH_OFFSET, (k % 2) ? 16'h8000 : 16'h7FFF);
         write_reg(REG_GYRO_OFFSET_X, (k % 2) ? 16'h8000 : 16'h7FFF);
         write_reg(REG_GYRO_OFFSET_Y, (k % 2) ? 16'h7FFF : 16'h8000);
         write_reg(REG_GYRO_OFFSET_Z, (k % 2) ? 16'h8000 : 16'h7FFF);
         repeat (2) send_sample(make_sample(0));
         send_sample(make_sample(1));
      end
   endtask

   task automatic test_result_backpressure();
      go_idle();
      rsp_hold = 400;
      repeat (8) send_sample(make_sample(0));
      go_idle();   // sender waits for every result
   endtask

   task automatic test_random_phases();
      for (int ph = 0; ph < 12; ph++) begin
         go_idle();
         for (int r = 0; r < 8; r++) begin
            if ($urandom_range(0, 2) == 0) write_reg(reg_index_type'(r), 16'($urandom));
            else case (reg_index_type'(r))
               REG_ROLL_OFFSET, REG_PITCH_OFFSET:
                  write_reg(reg_index_type'(r), 16'($urandom_range(0, 2000) - 1000));
               REG_BLEND_WEIGHT:
                  write_reg(reg_index_type'(r), 16'($urandom_range(0, 256)));
               REG_ANGLE_LIMIT:
                  write_reg(reg_index_type'(r), 16'($urandom_range(500, 23040)));
               REG_RATE_LIMIT:
                  write_reg(reg_index_type'(r), 16'($urandom_range(2000, 32767)));
               default:
                  write_reg(reg_index_type'(r), 16'($urandom_range(0, 400) - 200));
            endcase
         end
         no_gaps = (ph % 4 == 3);
         repeat (95) send_sample(make_sample(($urandom_range(0, 9) < 7) ? 0 : 1));
         no_gaps = 0;
      end
   endtask

   initial begin
      clock = 0;
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.accel_x <= '0; req_ch.accel_y <= '0; req_ch.accel_z <= '0;
      req_ch.rate_x <= '0; req_ch.rate_y <= '0; req_ch.rate_z <= '0;
      req_ch.elapsed_us <= '0;
      csr_ch.valid <= 1'b0;
      csr_ch.index <= REG_GYRO_OFFSET_X;
      csr_ch.data  <= '0;
      mismatches = 0;
      no_gaps = 0;
      rsp_hold = 0;
      reset_predictor();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_extremes();
      test_register_extremes();
      test_result_backpressure();
      test_random_phases();

      go_idle();
      repeat (300) @(posedge clock);
      if (mismatches == 0 && fused_expected.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin
      #5000000;
      $display("Verification failed");
      $finish;
   end

endmodule
